/* rtl/azma_pkg.sv */
// Shared types, widths, register indexes and reset values for the auto-zero moving average.
`default_nettype none
package azma_pkg;

	localparam int WINDOW_DEF = 16;
	localparam int SAMPLE_W   = 18;
	localparam int OFFSET_W   = 14;
	localparam int GSUM_W     = 22;
	localparam int CNT_W      = 8;
	localparam int DELTA_W    = 10;
	localparam int BAND_W     = 13;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_AUTO_CAL     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_DELTA = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_BAND    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_NEED  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES  = CFG_IDX_W'(4);

	localparam logic [DELTA_W-1:0] RST_STABLE_DELTA = DELTA_W'(10);
	localparam logic [BAND_W-1:0]  RST_ZERO_BAND    = BAND_W'(512);
	localparam logic [CNT_W-1:0]   RST_STABLE_NEED  = CNT_W'(10);
	localparam logic [CNT_W-1:0]   RST_CAL_SAMPLES  = CNT_W'(32);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAL,
		ST_OFF_WAIT,
		ST_UPDATE,
		ST_AVG,
		ST_AVG_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_sample;
		logic do_cal;
		logic load_offset;
		logic do_update;
		logic start_avg;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic cal_div;
		logic div_done;
	} stat_t;

endpackage
`default_nettype wire

/* rtl/azma_div.sv */
// Iterative signed-by-unsigned restoring divider, one quotient bit per cycle, truncating.
`default_nettype none
module azma_div #(
	parameter int DW = azma_pkg::GSUM_W,
	parameter int VW = azma_pkg::CNT_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [DW-1:0] num,
	input  wire logic        [VW-1:0] den,
	output logic                      done,
	output logic signed      [DW-1:0] quo
);
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] num_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] den_q;
	logic          neg_q;

	logic [VW:0]   rem_sh;
	logic [VW:0]   rem_sub;
	logic          ge;

	always_comb begin
		rem_sh  = {rem_q, num_q[DW-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DW-1];
			num_q <= num[DW-1] ? (~num + 1'b1) : num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], ge};
			rem_q <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? (~num_q + 1'b1) : num_q;

endmodule
`default_nettype wire

/* rtl/azma_dp.sv */
// Datapath: configuration, auto-zero tracking, window memory, sums and shared divider.
`default_nettype none
module azma_dp #(
	parameter int WINDOW = azma_pkg::WINDOW_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_we,
	input  wire logic        [azma_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic        [azma_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic signed [azma_pkg::SAMPLE_W-1:0]    sample,
	input  wire azma_pkg::cmd_t                          cmd,
	output azma_pkg::stat_t                              stat,
	output logic signed      [azma_pkg::SAMPLE_W-1:0]    average,
	output logic                                         calibrating,
	output logic signed      [azma_pkg::OFFSET_W-1:0]    zero_offset
);
	import azma_pkg::*;

	localparam int SW    = $clog2(WINDOW);
	localparam int SUM_W = SAMPLE_W + SW;
	localparam int VW    = ($clog2(WINDOW + 1) > CNT_W) ? $clog2(WINDOW + 1) : CNT_W;
	localparam int DW    = (SUM_W > GSUM_W) ? SUM_W : GSUM_W;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	logic                auto_cal_q;
	logic [DELTA_W-1:0]  delta_q;
	logic [BAND_W-1:0]   band_q;
	logic [CNT_W-1:0]    need_q;
	logic [CNT_W-1:0]    cals_q;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic        [CNT_W-1:0]    steady_q;
	logic                       gathering_q;
	logic signed [GSUM_W-1:0]   gsum_q;
	logic        [CNT_W-1:0]    gcnt_q;
	logic signed [OFFSET_W-1:0] offset_q;
	logic signed [SUM_W-1:0]    wsum_q;
	logic        [SW-1:0]       slot_q;
	logic                       full_q;
	logic signed [SAMPLE_W-1:0] window_q [WINDOW];
	logic signed [SAMPLE_W-1:0] rd_q;

	logic signed [SAMPLE_W-1:0] average_q;
	logic                       calibrating_q;
	logic signed [OFFSET_W-1:0] zero_offset_q;

	logic signed [SAMPLE_W:0]   dif;
	logic        [SAMPLE_W:0]   dif_mag;
	logic        [SAMPLE_W-1:0] s_mag;
	logic                       hit;
	logic        [CNT_W-1:0]    steady_inc;
	logic                       start_g;
	logic                       g_now;
	logic signed [GSUM_W-1:0]   gsum_add;
	logic        [CNT_W-1:0]    gcnt_add;
	logic                       finish;

	logic signed [SAMPLE_W:0]   corr_w;
	logic signed [SAMPLE_W-1:0] corr;
	logic signed [SAMPLE_W-1:0] old;
	logic signed [SUM_W-1:0]    wsum_nx;
	logic        [VW-1:0]       avg_den;

	logic                       div_start;
	logic signed [DW-1:0]       div_num;
	logic        [VW-1:0]       div_den;
	logic                       div_done;
	logic signed [DW-1:0]       div_quo;

	always_comb begin
		dif        = (SAMPLE_W+1)'(sample_q) - (SAMPLE_W+1)'(prev_q);
		dif_mag    = dif[SAMPLE_W] ? (~dif + 1'b1) : dif;
		s_mag      = sample_q[SAMPLE_W-1] ? (~sample_q + 1'b1) : sample_q;
		hit        = (dif_mag <= (SAMPLE_W+1)'(delta_q)) && (s_mag < SAMPLE_W'(band_q));
		steady_inc = (steady_q != {CNT_W{1'b1}}) ? steady_q + 1'b1 : steady_q;
		start_g    = hit && (steady_inc >= need_q) && !gathering_q;
		g_now      = gathering_q || start_g;
		gsum_add   = (start_g ? GSUM_W'(0) : gsum_q) + GSUM_W'(sample_q);
		gcnt_add   = (start_g ? CNT_W'(0) : gcnt_q) + 1'b1;
		finish     = hit && g_now && (gcnt_add >= cals_q);

		corr_w = (SAMPLE_W+1)'(sample_q) - (SAMPLE_W+1)'(offset_q);
		if (corr_w[SAMPLE_W] != corr_w[SAMPLE_W-1]) begin
			corr = corr_w[SAMPLE_W] ? S_MIN : S_MAX;
		end else begin
			corr = corr_w[SAMPLE_W-1:0];
		end
		old     = full_q ? rd_q : SAMPLE_W'(0);
		wsum_nx = wsum_q - SUM_W'(old) + SUM_W'(corr);
		avg_den = full_q ? VW'(WINDOW) : VW'(slot_q);

		div_start = (cmd.do_cal && auto_cal_q && finish) || cmd.start_avg;
		div_num   = cmd.start_avg ? DW'(wsum_q) : DW'(gsum_add);
		div_den   = cmd.start_avg ? avg_den : VW'(gcnt_add);

		stat.cal_div  = auto_cal_q && finish;
		stat.div_done = div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_cal_q <= 1'b1;
			delta_q    <= RST_STABLE_DELTA;
			band_q     <= RST_ZERO_BAND;
			need_q     <= RST_STABLE_NEED;
			cals_q     <= RST_CAL_SAMPLES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AUTO_CAL:     auto_cal_q <= cfg_data[0];
				REG_STABLE_DELTA: delta_q    <= cfg_data[DELTA_W-1:0];
				REG_ZERO_BAND:    band_q     <= cfg_data[BAND_W-1:0];
				REG_STABLE_NEED:  need_q     <= cfg_data[CNT_W-1:0];
				REG_CAL_SAMPLES:  cals_q     <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			steady_q    <= '0;
			gathering_q <= 1'b0;
			gsum_q      <= '0;
			gcnt_q      <= '0;
			offset_q    <= '0;
			wsum_q      <= '0;
			slot_q      <= '0;
			full_q      <= 1'b0;
		end else begin
			if (cmd.do_cal && auto_cal_q) begin
				prev_q <= sample_q;
				if (!hit || finish) begin
					steady_q    <= '0;
					gathering_q <= 1'b0;
					gsum_q      <= '0;
					gcnt_q      <= '0;
				end else begin
					steady_q    <= steady_inc;
					gathering_q <= g_now;
					if (g_now) begin
						gsum_q <= gsum_add;
						gcnt_q <= gcnt_add;
					end
				end
			end
			if (cmd.load_offset) begin
				offset_q <= div_quo[OFFSET_W-1:0];
			end
			if (cmd.do_update) begin
				wsum_q <= wsum_nx;
				if (slot_q == SW'(WINDOW - 1)) begin
					slot_q <= '0;
					full_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_update) begin
			window_q[slot_q] <= corr;
		end
		rd_q <= window_q[slot_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= sample;
		end
		if (cmd.load_out) begin
			average_q     <= div_quo[SAMPLE_W-1:0];
			calibrating_q <= gathering_q;
			zero_offset_q <= offset_q;
		end
	end

	azma_div #(
		.DW(DW),
		.VW(VW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign average     = average_q;
	assign calibrating = calibrating_q;
	assign zero_offset = zero_offset_q;

endmodule
`default_nettype wire

/* rtl/azma_ctrl.sv */
// Controller: sequences one sample beat through calibration, window update and division.
`default_nettype none
module azma_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire azma_pkg::stat_t stat,
	output azma_pkg::cmd_t       cmd
);
	import azma_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_sample = 1'b1;
					state_d         = ST_CAL;
				end
			end
			ST_CAL: begin
				cmd.do_cal = 1'b1;
				state_d    = stat.cal_div ? ST_OFF_WAIT : ST_UPDATE;
			end
			ST_OFF_WAIT: begin
				if (stat.div_done) begin
					cmd.load_offset = 1'b1;
					state_d         = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.do_update = 1'b1;
				state_d       = ST_AVG;
			end
			ST_AVG: begin
				cmd.start_avg = 1'b1;
				state_d       = ST_AVG_WAIT;
			end
			ST_AVG_WAIT: begin
				if (stat.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_accept_to_cal: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_CAL))
		else $error("accepted beat did not enter calibration step");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == ST_OFF_WAIT || state_q == ST_AVG_WAIT))
		else $error("divider finished outside a wait state");

	a_offset_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CAL && stat.cal_div) |=> (state_q == ST_OFF_WAIT))
		else $error("offset division not awaited");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("output beat raised outside the done state");

endmodule
`default_nettype wire

/* rtl/auto_zero_moving_average.sv */
// Top level of the auto-zero moving average: controller plus datapath.
//
// Input channel: sample with in_valid / in_stall; a beat moves when in_valid is
// high and in_stall low. Output channel: average, calibrating, zero_offset with
// out_valid / out_stall. Every input beat yields exactly one output beat.
// Configuration: cfg_we, cfg_index, cfg_data; write only while the block is idle.
// Indexes 0..4: auto_calibrate, stable_delta, zero_band, stable_needed and the
// gather length for the offset mean. Other indexes are ignored.
// One beat at a time: with the default window (divider width 22) the next beat
// is taken only after the result register has loaded; a completing calibration
// run adds an offset division before the window update. In general the divider
// width is D = max(22, 18 + clog2(WINDOW)), and the shared divider yields one
// quotient bit per cycle while busy.
// Reset empties the window (entries read as zero until filled), clears the offset and the
// calibration state, and loads the register defaults; no clearing pass.
// A result held in the output register while out_stall is high does not stop
// the next input beat; only its final load waits for the register to free up.
`default_nettype none
module auto_zero_moving_average #(
	parameter int WINDOW = azma_pkg::WINDOW_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic        [azma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [azma_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [azma_pkg::SAMPLE_W-1:0]  sample,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed      [azma_pkg::SAMPLE_W-1:0]  average,
	output logic                                      calibrating,
	output logic signed      [azma_pkg::OFFSET_W-1:0]  zero_offset
);
	import azma_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	azma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	azma_dp #(
		.WINDOW(WINDOW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.cmd        (cmd),
		.stat       (stat),
		.average    (average),
		.calibrating(calibrating),
		.zero_offset(zero_offset)
	);

endmodule
`default_nettype wire
